// ===== hw/rtl/nearest_seed_tagger_defines.svh =====
// assertion macros for the nearest seed tagger checker
`ifndef NEAREST_SEED_TAGGER_DEFINES_SVH
`define NEAREST_SEED_TAGGER_DEFINES_SVH

// checked while out of reset
`define NST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// checked at every edge, reset included
`define NST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed during reset");

`endif

// ===== hw/rtl/nst_pkg.sv =====
// shared constants and types of the nearest seed tagger
package nst_pkg;

  localparam int DEFAULT_MAX_SEEDS  = 64;
  localparam int DEFAULT_COORD_BITS = 16;

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_SEEDS_W = 7;
  localparam int MIN_TAG_W   = 16;
  localparam int TAG_W       = 17;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_SEEDS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_TAG   = 2'd1;

  localparam logic [NUM_SEEDS_W-1:0] NUM_SEEDS_RESET = 7'd1;

  // control from the sequencer to the minimum tracker
  typedef struct packed {
    logic clear;
    logic valid;
  } nst_ctl_t;

endpackage

// ===== hw/rtl/nst_ram.sv =====
// generic single write port ram with registered read
module nst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nst_dist_unit.sv =====
// pipelined squared distance unit, one seed per cycle
module nst_dist_unit #(
  parameter int COORD_BITS = nst_pkg::DEFAULT_COORD_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [3*COORD_BITS-1:0]   seed_i,
  input  logic [3*COORD_BITS-1:0]   pos_i,
  output logic                      sq_valid_o,
  output logic [3*2*COORD_BITS-1:0] sq_o,
  output logic                      busy_o
);

  localparam int SQ_W = 2 * COORD_BITS;

  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [COORD_BITS-1:0] sc [3];
  logic signed [COORD_BITS:0]   diff [3];
  logic [COORD_BITS-1:0]        absd_d [3];
  logic [COORD_BITS-1:0]        absd_q [3];
  logic [SQ_W-1:0]              sq_q [3];
  logic                         absd_valid_q;
  logic                         sq_valid_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pc[c]     = signed'(pos_i[c*COORD_BITS +: COORD_BITS]);
      sc[c]     = signed'(seed_i[c*COORD_BITS +: COORD_BITS]);
      diff[c]   = {pc[c][COORD_BITS-1], pc[c]} - {sc[c][COORD_BITS-1], sc[c]};
      absd_d[c] = diff[c][COORD_BITS] ? COORD_BITS'(-diff[c]) : COORD_BITS'(diff[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      absd_valid_q <= 1'b0;
      sq_valid_q   <= 1'b0;
    end else begin
      absd_valid_q <= valid_i;
      sq_valid_q   <= absd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      absd_q[c] <= absd_d[c];
      sq_q[c]   <= SQ_W'(absd_q[c]) * SQ_W'(absd_q[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq_o[c*SQ_W +: SQ_W] = sq_q[c];
    end
  end

  assign sq_valid_o = sq_valid_q;
  assign busy_o     = absd_valid_q | sq_valid_q;

endmodule

// ===== hw/rtl/nst_min_tracker.sv =====
// running minimum of the squared distances, lower index wins ties
module nst_min_tracker #(
  parameter int MAX_SEEDS  = nst_pkg::DEFAULT_MAX_SEEDS,
  parameter int COORD_BITS = nst_pkg::DEFAULT_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nst_pkg::nst_ctl_t            ctl_i,
  input  logic [3*2*COORD_BITS-1:0]    sq_i,
  output logic [$clog2(MAX_SEEDS)-1:0] best_idx_o,
  output logic [2*COORD_BITS+1:0]      best_dist_o
);

  localparam int IDX_W  = $clog2(MAX_SEEDS);
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic [DIST_W-1:0] sum;
  logic              take;
  logic              have_best_q;
  logic [IDX_W-1:0]  idx_cnt_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [DIST_W-1:0] best_dist_q;

  assign sum  = DIST_W'(sq_i[0 +: SQ_W]) + DIST_W'(sq_i[SQ_W +: SQ_W])
              + DIST_W'(sq_i[2*SQ_W +: SQ_W]);
  assign take = ctl_i.valid && (!have_best_q || (sum < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      idx_cnt_q   <= '0;
    end else if (ctl_i.clear) begin
      have_best_q <= 1'b0;
      idx_cnt_q   <= '0;
    end else if (ctl_i.valid) begin
      have_best_q <= 1'b1;
      idx_cnt_q   <= idx_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= idx_cnt_q;
      best_dist_q <= sum;
    end
  end

  assign best_idx_o  = best_idx_q;
  assign best_dist_o = best_dist_q;

endmodule

// ===== hw/rtl/nearest_seed_tagger.sv =====
// top level of the nearest seed tagger
// usage:
//   cfg channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 sets num_seeds, index 1 sets min_tag, others are ignored;
//   write it only while the block is idle
//   input channel: in_valid_i/in_stall_o; op 0 stores a seed word and
//   returns nothing, op 1 classifies a particle position
//   a classification reads one seed per cycle from the seed ram and runs
//   it through the distance pipeline; num_seeds is clamped to 1..MAX_SEEDS;
//   the input stalls until its word is loaded into the output register
//   output channel: out_valid_o/out_stall_i; one word per classification,
//   held in an output register; a new item is taken while it waits, and a
//   finished search waits for the register to free up
//   reset clears control state and sets num_seeds to 1 and min_tag to 0;
//   seed entries hold nothing defined until written
module nearest_seed_tagger #(
  parameter int MAX_SEEDS  = nst_pkg::DEFAULT_MAX_SEEDS,
  parameter int COORD_BITS = nst_pkg::DEFAULT_COORD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nst_pkg::CFG_ADDR_W-1:0]     cfg_index_i,
  input  logic [nst_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [$clog2(MAX_SEEDS)-1:0]       seed_index_i,
  input  logic signed [COORD_BITS-1:0]       pos_x_i,
  input  logic signed [COORD_BITS-1:0]       pos_y_i,
  input  logic signed [COORD_BITS-1:0]       pos_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [$clog2(MAX_SEEDS)-1:0]       nearest_index_o,
  output logic [nst_pkg::TAG_W-1:0]          grain_tag_o,
  output logic [2*COORD_BITS+1:0]            nearest_dist_sq_o
);

  localparam int IDX_W  = $clog2(MAX_SEEDS);
  localparam int CNT_W  = $clog2(MAX_SEEDS + 1);
  localparam int SEED_W = 3 * COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } nst_state_e;

  nst_state_e state_q, state_d;

  logic [nst_pkg::NUM_SEEDS_W-1:0] num_seeds_q;
  logic [nst_pkg::MIN_TAG_W-1:0]   min_tag_q;
  logic [CNT_W-1:0]                issue_cnt_q, issue_cnt_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [CNT_W-1:0]                count_clamped;
  logic [SEED_W-1:0]               pos_q, pos_d;
  logic                            rd_valid_q;
  logic                            rd_en;
  logic                            in_accept;
  logic                            start;
  logic                            seed_we;
  logic                            drained;
  logic                            out_load;
  logic                            out_valid_q;
  logic [IDX_W-1:0]                out_index_q;
  logic [nst_pkg::TAG_W-1:0]       out_tag_q;
  logic [DIST_W-1:0]               out_dist_q;
  logic [SEED_W-1:0]               seed_rdata;
  logic                            sq_valid;
  logic [3*SQ_W-1:0]               sq;
  logic                            dist_busy;
  nst_pkg::nst_ctl_t               trk_ctl;
  logic [IDX_W-1:0]                best_idx;
  logic [DIST_W-1:0]               best_dist;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign start       = in_accept && (op_i == nst_pkg::OP_CLASSIFY);
  assign seed_we     = in_accept && (op_i == nst_pkg::OP_WRITE)
                     && (32'(seed_index_i) < MAX_SEEDS);
  assign drained     = !rd_valid_q && !dist_busy && !sq_valid;

  // seed count of zero means one, large counts stop at the table size
  always_comb begin
    if (num_seeds_q == '0) begin
      count_clamped = CNT_W'(1);
    end else if (32'(num_seeds_q) > MAX_SEEDS) begin
      count_clamped = CNT_W'(MAX_SEEDS);
    end else begin
      count_clamped = CNT_W'(num_seeds_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    count_d     = count_q;
    pos_d       = pos_q;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          pos_d       = {pos_z_i, pos_y_i, pos_x_i};
          count_d     = count_clamped;
          issue_cnt_d = '0;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        rd_en       = 1'b1;
        issue_cnt_d = issue_cnt_q + 1'b1;
        if (issue_cnt_q == (count_q - CNT_W'(1))) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained && (!out_valid_q || !out_stall_i)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_cnt_q <= '0;
      count_q     <= CNT_W'(1);
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      num_seeds_q <= nst_pkg::NUM_SEEDS_RESET;
      min_tag_q   <= '0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      count_q     <= count_d;
      rd_valid_q  <= rd_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          nst_pkg::REG_NUM_SEEDS: num_seeds_q <= nst_pkg::NUM_SEEDS_W'(cfg_data_i);
          nst_pkg::REG_MIN_TAG:   min_tag_q   <= nst_pkg::MIN_TAG_W'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (out_load) begin
      out_index_q <= best_idx;
      out_tag_q   <= nst_pkg::TAG_W'(min_tag_q) + nst_pkg::TAG_W'(best_idx);
      out_dist_q  <= best_dist;
    end
  end

  nst_ram #(
    .WIDTH (SEED_W),
    .DEPTH (MAX_SEEDS)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (seed_we),
    .waddr_i (seed_index_i),
    .wdata_i ({pos_z_i, pos_y_i, pos_x_i}),
    .re_i    (rd_en),
    .raddr_i (issue_cnt_q[IDX_W-1:0]),
    .rdata_o (seed_rdata)
  );

  nst_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rd_valid_q),
    .seed_i     (seed_rdata),
    .pos_i      (pos_q),
    .sq_valid_o (sq_valid),
    .sq_o       (sq),
    .busy_o     (dist_busy)
  );

  assign trk_ctl.clear = start;
  assign trk_ctl.valid = sq_valid;

  nst_min_tracker #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_min_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (trk_ctl),
    .sq_i        (sq),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist)
  );

  assign out_valid_o       = out_valid_q;
  assign nearest_index_o   = out_index_q;
  assign grain_tag_o       = out_tag_q;
  assign nearest_dist_sq_o = out_dist_q;

endmodule

// ===== hw/rtl/nst_checker.sv =====
// port level checker of the nearest seed tagger and its bind
`include "nearest_seed_tagger_defines.svh"

module nst_checker #(
  parameter int MAX_SEEDS  = nst_pkg::DEFAULT_MAX_SEEDS,
  parameter int COORD_BITS = nst_pkg::DEFAULT_COORD_BITS
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         op_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [$clog2(MAX_SEEDS)-1:0] nearest_index_o,
  input logic [2*COORD_BITS+1:0]      nearest_dist_sq_o
);

  `NST_ASSERT(a_out_held, out_valid_o && out_stall_i |=> out_valid_o)
  `NST_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(nearest_index_o) && $stable(nearest_dist_sq_o))
  `NST_ASSERT(a_classify_busy, in_valid_i && !in_stall_o && (op_i == nst_pkg::OP_CLASSIFY) |=> in_stall_o)
  `NST_ASSERT(a_write_no_word, in_valid_i && !in_stall_o && (op_i == nst_pkg::OP_WRITE) && !out_valid_o |=> !out_valid_o)
  `NST_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule

bind nearest_seed_tagger nst_checker #(
  .MAX_SEEDS  (MAX_SEEDS),
  .COORD_BITS (COORD_BITS)
) u_nst_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .op_i              (op_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .nearest_index_o   (nearest_index_o),
  .nearest_dist_sq_o (nearest_dist_sq_o)
);

// ===== dv/tb_top.sv =====
// self-checking bench for the nearest seed tagger: seed writes, classification and tag checks
`timescale 1ns / 100ps

module tb_top;
  import nst_pkg::*;

  localparam int SEEDS = DEFAULT_MAX_SEEDS;
  localparam int COORD = DEFAULT_COORD_BITS;
  localparam int IDX_W = $clog2(SEEDS);
  localparam int DIST_W = 2 * COORD + 2;
  localparam int PHASE_WORDS = 290;
  localparam int SETTLE_CYCLES = SEEDS + 10;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  typedef logic signed [COORD-1:0] coord_t;

  localparam coord_t C_LO = 16'h8000;
  localparam coord_t C_HI = 16'h7fff;

  typedef struct packed {
    logic [IDX_W-1:0]  seed;
    logic [TAG_W-1:0]  tag;
    logic [DIST_W-1:0] dist_sq;
  } tag_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  op;
    logic [IDX_W-1:0]      idx;
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    tag_result_t           want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  op_i;
  logic [IDX_W-1:0]      seed_index_i;
  coord_t                pos_x_i;
  coord_t                pos_y_i;
  coord_t                pos_z_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [IDX_W-1:0]      nearest_index_o;
  logic [TAG_W-1:0]      grain_tag_o;
  logic [DIST_W-1:0]     nearest_dist_sq_o;

  nearest_seed_tagger i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .seed_index_i     (seed_index_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .nearest_index_o  (nearest_index_o),
    .grain_tag_o      (grain_tag_o),
    .nearest_dist_sq_o(nearest_dist_sq_o)
  );

  coord_t                 seed_x [SEEDS];
  coord_t                 seed_y [SEEDS];
  coord_t                 seed_z [SEEDS];
  bit                     seed_written [SEEDS];
  logic [NUM_SEEDS_W-1:0] cfg_num_seeds;
  logic [MIN_TAG_W-1:0]   cfg_min_tag;
  tag_result_t            owed_tags [$];
  int                     mismatch_count;
  bit                     no_idle;
  bit                     hold_req;
  int                     cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int seeds_searched();
    if (cfg_num_seeds == 0) return 1;
    if (cfg_num_seeds > SEEDS) return SEEDS;
    return int'(cfg_num_seeds);
  endfunction

  function automatic longint sq_diff(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic tag_result_t find_nearest_seed(coord_t px, coord_t py, coord_t pz);
    tag_result_t r;
    longint      d_sum;
    longint      best;
    int          best_i;
    best = 0;
    best_i = 0;
    for (int i = 0; i < seeds_searched(); i++) begin
      d_sum = sq_diff(px, seed_x[i]) + sq_diff(py, seed_y[i]) + sq_diff(pz, seed_z[i]);
      if (i == 0 || d_sum < best) begin
        best = d_sum;
        best_i = i;
      end
    end
    r.seed = IDX_W'(best_i);
    r.tag = TAG_W'(best_i + int'(cfg_min_tag));
    r.dist_sq = DIST_W'(best);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: %s got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_word();
    tag_result_t want;
    if (owed_tags.size() == 0) begin
      report_mismatch("word with nothing owed, nearest_index", nearest_index_o, 0);
      return;
    end
    want = owed_tags.pop_front();
    if (nearest_index_o !== want.seed)
      report_mismatch("nearest_index", nearest_index_o, want.seed);
    if (grain_tag_o !== want.tag)
      report_mismatch("grain_tag", grain_tag_o, want.tag);
    if (nearest_dist_sq_o !== want.dist_sq)
      report_mismatch("nearest_dist_sq", nearest_dist_sq_o, want.dist_sq);
  endtask

  // called at a rising edge; returns at the edge that takes the word
  task automatic offer_word(logic op, logic [IDX_W-1:0] idx, coord_t x, coord_t y, coord_t z,
                            logic typed, tag_result_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    seed_index_i <= idx;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_WRITE) begin
      seed_x[idx] = x;
      seed_y[idx] = y;
      seed_z[idx] = z;
      seed_written[idx] = 1'b1;
    end else begin
      owed_tags.insert(owed_tags.size(), typed ? want : find_nearest_seed(x, y, z));
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (owed_tags.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_NUM_SEEDS: cfg_num_seeds = data[NUM_SEEDS_W-1:0];
      REG_MIN_TAG:   cfg_min_tag = data[MIN_TAG_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(0, 7))
      0: return C_LO;
      1: return C_HI;
      2: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t near_coord(coord_t c);
    return c + coord_t'($urandom_range(0, 8)) - coord_t'(4);
  endfunction

  task automatic random_word();
    int     n;
    int     hole;
    int     j;
    coord_t x;
    coord_t y;
    coord_t z;
    n = seeds_searched();
    hole = -1;
    for (int i = n - 1; i >= 0; i--)
      if (!seed_written[i]) hole = i;
    x = any_coord();
    y = any_coord();
    z = any_coord();
    if (hole >= 0) begin
      offer_word(OP_WRITE, IDX_W'(hole), x, y, z, 1'b0, '0);
    end else if ($urandom_range(0, 9) < 3) begin
      // copies of live seeds make equal distances
      if ($urandom_range(0, 4) == 0) begin
        j = $urandom_range(0, n - 1);
        x = seed_x[j];
        y = seed_y[j];
        z = seed_z[j];
      end
      offer_word(OP_WRITE, IDX_W'($urandom_range(0, SEEDS - 1)), x, y, z, 1'b0, '0);
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        j = $urandom_range(0, n - 1);
        x = near_coord(seed_x[j]);
        y = near_coord(seed_y[j]);
        z = near_coord(seed_z[j]);
      end
      offer_word(OP_CLASSIFY, IDX_W'($urandom), x, y, z, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t word_row(logic op, logic [IDX_W-1:0] idx,
                                         coord_t x, coord_t y, coord_t z);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.op = op;
    r.idx = idx;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic stim_row_t known_row(coord_t x, coord_t y, coord_t z, logic [IDX_W-1:0] s,
                                          logic [TAG_W-1:0] t, logic [DIST_W-1:0] d);
    stim_row_t r;
    r = word_row(OP_CLASSIFY, '0, x, y, z);
    r.typed = 1'b1;
    r.want.seed = s;
    r.want.tag = t;
    r.want.dist_sq = d;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = a;
    r.reg_data = d;
    return r;
  endfunction

  initial begin : rx
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        check_word();
        stall_left = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stim
    stim_row_t              rows [$];
    logic [NUM_SEEDS_W-1:0] cnt;
    logic [CFG_DATA_W-1:0]  data;
    logic [MIN_TAG_W-1:0]   tag_base;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    op_i <= OP_WRITE;
    seed_index_i <= '0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    pos_z_i <= '0;
    cfg_num_seeds = NUM_SEEDS_RESET;
    cfg_min_tag = '0;
    mismatch_count = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    foreach (seed_written[i]) seed_written[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.insert(rows.size(), word_row(OP_WRITE, 0, 0, 0, 0));
    rows.insert(rows.size(), known_row(0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), known_row(C_LO, C_LO, C_LO, 0, 0, 34'd3221225472));
    rows.insert(rows.size(), known_row(C_HI, C_HI, C_HI, 0, 0, 34'd3221028867));
    rows.insert(rows.size(), word_row(OP_WRITE, 0, C_LO, C_LO, C_LO));
    rows.insert(rows.size(), known_row(C_HI, C_HI, C_HI, 0, 0, 34'd12884508675));
    rows.insert(rows.size(), word_row(OP_WRITE, 1, 10, 20, 30));
    rows.insert(rows.size(), word_row(OP_WRITE, 2, -10, 20, 30));
    rows.insert(rows.size(), word_row(OP_WRITE, 63, C_HI, C_LO, C_HI));
    // zero count still searches seed 0
    rows.insert(rows.size(), reg_row(REG_NUM_SEEDS, 16'h0000));
    rows.insert(rows.size(), word_row(OP_CLASSIFY, 63, 10, 20, 30));
    rows.insert(rows.size(), reg_row(REG_NUM_SEEDS, 16'h0003));
    rows.insert(rows.size(), reg_row(REG_MIN_TAG, 16'hffff));
    // equal distance to seeds 1 and 2, lower index wins
    rows.insert(rows.size(), known_row(0, 20, 30, 1, 17'd65536, 34'd100));
    rows.insert(rows.size(), reg_row(REG_SPARE_A, 16'hffff));
    rows.insert(rows.size(), reg_row(REG_SPARE_B, 16'h0001));
    rows.insert(rows.size(), word_row(OP_CLASSIFY, 0, -10, 20, 30));
    rows.insert(rows.size(), reg_row(REG_MIN_TAG, 16'h0000));
    rows.insert(rows.size(), word_row(OP_CLASSIFY, 0, 5, 20, 30));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        offer_word(rows[i].op, rows[i].idx, rows[i].x, rows[i].y, rows[i].z,
                   rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: begin cnt = SEEDS; tag_base = 16'hffff; end
        1: begin cnt = 7'd127; tag_base = 16'h0000; end
        2: begin cnt = 7'd1; tag_base = MIN_TAG_W'($urandom); end
        3: begin cnt = 7'd0; tag_base = 16'hffff; end
        4: begin cnt = NUM_SEEDS_W'($urandom_range(1, SEEDS)); tag_base = MIN_TAG_W'($urandom); end
        5: begin
          cnt = NUM_SEEDS_W'($urandom_range(SEEDS + 1, 127));
          tag_base = MIN_TAG_W'($urandom);
        end
        default: begin cnt = NUM_SEEDS_W'($urandom); tag_base = MIN_TAG_W'($urandom); end
      endcase
      data = CFG_DATA_W'($urandom);
      data[NUM_SEEDS_W-1:0] = cnt;
      write_reg(REG_NUM_SEEDS, data);
      write_reg(REG_MIN_TAG, tag_base);
      if (p == 2) write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
      no_idle = (p == 6);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // long output hold while words keep coming
        if (p == 0 && n == 120) hold_req = 1'b1;
        random_word();
      end
    end

    wait_idle();
    if (mismatch_count == 0 && owed_tags.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
